[design/fmm_pkg.sv]
// Package: shared constants, types and controller states for the floor match multiset.
`default_nettype none
package fmm_pkg;
    localparam int CAPACITY   = 1024;
    localparam int PRICE_BITS = 32;
    localparam int ADDR_BITS  = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);

    typedef logic [PRICE_BITS-1:0] price_t;
    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;

    localparam logic [1:0] ST_STORED = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_MATCH  = 2'd2;
    localparam logic [1:0] ST_NONE   = 2'd3;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_RESULT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input word, start scan at top
        logic scan_step;  // advance scan one entry down
        logic up_step;    // final insert of the new value
        logic dn_step;    // move one entry down
        logic out_load;   // latch result
        logic [1:0] out_status;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_query;
        logic full;
        logic empty;
        logic scan_done;   // ptr reached 0 or entry below ptr is <= price
        logic shift_done;
        logic out_busy;
        logic found;
    } sts_t;
endpackage
`default_nettype wire

[design/floor_match_multiset_core.sv]
// Top level: floor match multiset, controller plus datapath over one sorted RAM.
// Sequence: an add scans down from the top, moving each entry above the new value up
// one slot through the RAM's single write port, then writes the value; a dropped add
// (store full) goes straight to the result; a query scans down to the first entry <=
// price and, on a match, shifts the entries above it down one slot. Stalls add cycles.
// Throughput: one word at a time; the next word is taken the cycle after the result is
// latched. Reset: rst_n clears the entry count and control state; RAM stays undefined.
`default_nettype none
module floor_match_multiset_core
    import fmm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        mode,
    input  wire logic [31:0] price,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [31:0]      matched_price
);
    cmd_t cmd;
    sts_t sts;
    logic in_fire;

    // a word is taken only in idle, so config of the scan always starts clean
    assign in_fire = in_valid && in_ready;

    fmm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_fire(in_fire),
        .sts    (sts),
        .ready  (in_ready),
        .cmd    (cmd)
    );

    fmm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_mode   (mode),
        .in_price  (price_t'(price)),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_status(status),
        .out_price (matched_price)
    );
endmodule
`default_nettype wire

[design/fmm_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module fmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[design/fmm_ctrl.sv]
// Controller state machine: sequences scan, shift and result phases.
`default_nettype none
module fmm_ctrl
    import fmm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_fire,
    input  wire sts_t sts,
    output logic      ready,
    output cmd_t      cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.is_query && sts.empty)
                begin
                    state_next = S_RESULT;
                end
                else if (!sts.is_query && sts.full)
                begin
                    state_next = S_RESULT;
                end
                else if (sts.scan_done)
                begin
                    if (sts.is_query)
                    begin
                        state_next = sts.found ? S_SHIFT_DN : S_RESULT;
                    end
                    else
                    begin
                        state_next = S_SHIFT_UP;
                    end
                end
            end
            S_SHIFT_UP: state_next = S_RESULT;
            S_SHIFT_DN:
            begin
                if (sts.shift_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                ready    = 1'b1;
                cmd.load = in_fire;
            end
            S_SCAN:
            begin
                if (!(sts.is_query ? sts.empty : sts.full) && !sts.scan_done)
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_SHIFT_UP: cmd.up_step = 1'b1;
            S_SHIFT_DN: cmd.dn_step = !sts.shift_done;
            S_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.is_query)
                    begin
                        cmd.out_status = sts.found ? ST_MATCH : ST_NONE;
                    end
                    else
                    begin
                        cmd.out_status = sts.full ? ST_FULL : ST_STORED;
                    end
                end
            end
            default: cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

[design/fmm_dp.sv]
// Datapath: sorted store in RAM, scan pointer, shift engine and output register.
`default_nettype none
module fmm_dp
    import fmm_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cmd_t   cmd,
    output sts_t        sts,
    input  wire logic   in_mode,
    input  wire price_t in_price,
    input  wire logic   out_ready,
    output logic        out_valid,
    output logic [1:0]  out_status,
    output price_t      out_price
);
    cnt_t   count_reg, count_next;
    cnt_t   ptr_reg, ptr_next;      // scan pointer: entries [0,ptr) unchecked
    cnt_t   end_reg, end_next;      // shift-down end
    logic   mode_reg;
    price_t price_reg;
    price_t found_reg;
    logic   found_reg_v;
    logic   full_reg;               // store was full when the word was taken
    logic   rd_pend_reg;            // rdata valid: store[ptr-1] in scan, store[ptr+1] in shift-down
    logic   out_valid_reg;
    logic [1:0] out_status_reg;
    price_t out_price_reg;

    logic   we;
    addr_t  waddr, raddr;
    price_t wdata, rdata;

    fmm_ram #(.WIDTH(PRICE_BITS), .DEPTH(CAPACITY)) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    // scan: rdata is store[ptr-1]; stop when it is <= price (add stops when > is false too)
    logic below_ok;
    assign below_ok = rd_pend_reg && (rdata <= price_reg);

    assign sts.is_query   = mode_reg;
    assign sts.full       = full_reg;
    assign sts.empty      = (count_reg == '0);
    assign sts.scan_done  = (ptr_reg == '0) || below_ok;
    assign sts.found      = mode_reg ? (found_reg_v || below_ok) : 1'b0;
    assign sts.shift_done = (ptr_reg + cnt_t'(1) >= end_reg);
    assign sts.out_busy   = out_valid_reg && !out_ready;

    // Add scan: each step moves store[ptr-1] up to store[ptr] (it is > price).
    // Shift-down: store[ptr] <= store[ptr+1], read ahead ptr+2.
    always_comb
    begin
        we         = 1'b0;
        waddr      = addr_t'(ptr_reg);
        wdata      = rdata;
        raddr      = addr_t'(ptr_reg - cnt_t'(1));
        ptr_next   = ptr_reg;
        end_next   = end_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            ptr_next = count_reg;
            raddr    = addr_t'(count_reg - cnt_t'(1));
        end
        else if (cmd.scan_step)
        begin
            if (rd_pend_reg)
            begin
                if (!mode_reg)
                begin
                    we    = 1'b1;
                    waddr = addr_t'(ptr_reg);
                end
                ptr_next = ptr_reg - cnt_t'(1);
                raddr    = addr_t'(ptr_reg - cnt_t'(2));
            end
        end
        else if (cmd.up_step)
        begin
            we         = 1'b1;
            waddr      = addr_t'(ptr_reg);
            wdata      = price_reg;
            count_next = count_reg + cnt_t'(1);
        end
        else if (cmd.dn_step)
        begin
            if (rd_pend_reg)
            begin
                we       = 1'b1;
                waddr    = addr_t'(ptr_reg);
                ptr_next = ptr_reg + cnt_t'(1);
                raddr    = addr_t'(ptr_reg + cnt_t'(2));
            end
            else
            begin
                raddr = addr_t'(ptr_reg + cnt_t'(1));
            end
        end
        // entering shift-down: matched entry at ptr-1
        if (cmd.scan_step == 1'b0 && mode_reg && below_ok && !found_reg_v)
        begin
            ptr_next   = ptr_reg - cnt_t'(1);
            end_next   = count_reg;
            count_next = count_reg - cnt_t'(1);
            raddr      = addr_t'(ptr_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            found_reg_v   <= 1'b0;
            full_reg      <= 1'b0;
            rd_pend_reg   <= 1'b0;
            ptr_reg       <= '0;
            end_reg       <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            end_reg   <= end_next;
            if (cmd.load)
            begin
                full_reg <= (count_reg == cnt_t'(CAPACITY));
            end
            if (cmd.load)
            begin
                found_reg_v <= 1'b0;
                rd_pend_reg <= (count_reg != '0);
            end
            else if (mode_reg && below_ok && !found_reg_v && !cmd.scan_step)
            begin
                found_reg_v <= 1'b1;
                rd_pend_reg <= 1'b0;
            end
            else if (cmd.dn_step)
            begin
                rd_pend_reg <= 1'b1;
            end
            else if (cmd.scan_step)
            begin
                rd_pend_reg <= (ptr_reg > cnt_t'(1));
            end
            else if (!cmd.dn_step)
            begin
                rd_pend_reg <= rd_pend_reg;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= in_mode;
            price_reg <= in_price;
        end
        if (mode_reg && below_ok && !found_reg_v && !cmd.scan_step)
        begin
            found_reg <= rdata;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            out_price_reg  <= (cmd.out_status == ST_MATCH) ? found_reg : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_price  = out_price_reg;
endmodule
`default_nettype wire

[design/fmm_checker.sv]
// Port-level checker for the floor match multiset, bound to the top level.
`default_nettype none
module fmm_checker
    import fmm_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  status,
    input wire logic [31:0] matched_price
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped while stalled");

    a_price_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_MATCH |-> matched_price == '0)
        else $error("nonzero price without match");

    a_no_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken before result");

    a_no_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid || $past(out_valid))
        else $error("result appeared too soon");
endmodule

bind floor_match_multiset_core fmm_checker u_fmm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .matched_price(matched_price)
);
`default_nettype wire

[tb/tb_floor_match_multiset_core.sv]
// Testbench for floor_match_multiset_core: queue-driven stimulus, sorted-multiset predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_floor_match_multiset_core;
    import fmm_pkg::*;

    // One input word: operation plus price.
    typedef struct {
        logic         op;
        logic [31:0]  price;
    } word_t;

    // One result word.
    typedef struct {
        logic [1:0]   status;
        logic [31:0]  matched;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        mode;
    logic [31:0] price;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [31:0] matched_price;
    logic        in_ready_seen;

    word_t       pending_words[$];
    answer_t     expected_answers[$];
    logic [31:0] shelf[$];          // predictor copy of the multiset, ascending
    int          error_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    longint      cycle_count;

    floor_match_multiset_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .price         (price),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .matched_price (matched_price)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Predictor: insert keeps ascending order; query takes the largest value <= price
    // and removes one copy of it.
    function automatic answer_t predict_trade(word_t w);
        answer_t a;
        int      pos;
        a.status  = ST_STORED;
        a.matched = '0;
        if (w.op == MODE_ADD)
        begin
            if (shelf.size() >= CAPACITY)
                a.status = ST_FULL;
            else
            begin
                pos = shelf.size();
                while (pos > 0 && shelf[pos-1] > w.price)
                    pos--;
                shelf.insert(pos, w.price);
            end
        end
        else
        begin
            pos = shelf.size();
            while (pos > 0 && shelf[pos-1] > w.price)
                pos--;
            if (pos == 0)
                a.status = ST_NONE;
            else
            begin
                a.status  = ST_MATCH;
                a.matched = shelf[pos-1];
                shelf.delete(pos-1);
            end
        end
        return a;
    endfunction

    // Driver: after a handshake or while idle, present the next word at the falling edge.
    // Valid holds until accepted; a back-to-back word replaces the payload with valid high.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready_seen)
            begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    mode     <= pending_words[0].op;
                    price    <= pending_words[0].price;
                    expected_answers.push_back(predict_trade(pending_words.pop_front()));
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Handshake flag sampled at the rising edge so the driver never races the DUT.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_ready_seen <= 1'b0;
        else
            in_ready_seen <= in_valid && in_ready;
    end

    // Monitor: compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_answers.size() == 0)
            begin
                $error("result with nothing expected: status=%0d matched_price=%0h",
                       status, matched_price);
                error_count++;
            end
            else
            begin
                answer_t e;
                e = expected_answers.pop_front();
                if (status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, status);
                    error_count++;
                end
                if (matched_price !== e.matched)
                begin
                    $error("matched_price: expected %0h, got %0h", e.matched, matched_price);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: worst case is roughly 2000 words, each scanning or shifting the full store, plus stalls.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 64'd20_000_000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [31:0] rand_price(int span);
        // mostly a narrow range so queries hit and duplicates show up
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return 32'hFFFF_FFFF - $urandom_range(3);
            2:       return $urandom_range(3);
            default: return $urandom_range(span);
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_words.size() > 0 || expected_answers.size() > 0 || in_valid)
            @(posedge clk);
    endtask

    task automatic push_word(logic op, logic [31:0] p);
        word_t w;
        w.op    = op;
        w.price = p;
        pending_words.push_back(w);
    endtask

    initial
    begin
        int phase;
        int n;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        mode           = MODE_ADD;
        price          = '0;
        out_ready      = 1'b0;
        error_count    = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty query, extremes, duplicates, exact and below-floor matches.
        push_word(MODE_QUERY, 32'hFFFF_FFFF);
        push_word(MODE_ADD,   32'h0000_0000);
        push_word(MODE_ADD,   32'hFFFF_FFFF);
        push_word(MODE_ADD,   32'd500);
        push_word(MODE_ADD,   32'd500);
        push_word(MODE_ADD,   32'd100);
        push_word(MODE_QUERY, 32'd499);
        push_word(MODE_QUERY, 32'd500);
        push_word(MODE_QUERY, 32'd500);
        push_word(MODE_QUERY, 32'd500);
        push_word(MODE_QUERY, 32'd0);
        push_word(MODE_QUERY, 32'd0);
        push_word(MODE_QUERY, 32'hFFFF_FFFE);
        push_word(MODE_QUERY, 32'hFFFF_FFFF);
        push_word(MODE_QUERY, 32'hFFFF_FFFF);
        push_word(MODE_ADD,   32'hAAAA_5555);
        push_word(MODE_QUERY, 32'h5555_AAAA);
        push_word(MODE_QUERY, 32'hAAAA_5555);
        wait_drained();

        // Fill to capacity once, hit the full case, then take the top half back out.
        for (int i = 0; i < CAPACITY + 2; i++)
            push_word(MODE_ADD, $urandom);
        for (int i = 0; i < CAPACITY / 2; i++)
            push_word(MODE_QUERY, 32'hFFFF_FFFF - $urandom_range(1));
        wait_drained();

        // Random phases: none / sender idle / receiver stall / both.
        for (phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 46 : (phase == 3) ? 26 : 0;
            recv_stall_pct = (phase == 2) ? 46 : (phase == 3) ? 26 : 0;
            n = 110;
            for (int i = 0; i < n; i++)
            begin
                // lean toward queries while the store is deep
                if (shelf.size() + pending_words.size() > 40 && $urandom_range(1))
                    push_word(MODE_QUERY, rand_price(1000));
                else
                    push_word(logic'($urandom_range(1)), rand_price(1000));
            end
            wait_drained();
        end

        repeat (3000) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
